// ===== hw/rtl/mmx_pkg.sv =====
// Shared types, constants, mixing tables and coefficient arithmetic of the motor mixer.
package mmx_pkg;

    localparam int NUM_FRAMES   = 12;
    localparam int TABLE_MOTORS = 8;
    localparam int NUM_REGS     = 8;
    localparam int CNT_W        = 4;
    localparam int TAB_IDX_W    = 3;
    localparam int OUT_IDX_W    = 3;
    localparam int FRAME_W      = 4;
    localparam int CMD_W        = 12;
    localparam int CORR_W       = 13;
    localparam int TERM_W       = 14;
    localparam int MIX_W        = 16;
    localparam int SH_W         = 16;
    localparam int VAL_W        = 17;
    localparam int PRD_W        = 16;
    localparam int MUL_W        = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 5;
    localparam int DEF_MAX_MOTORS = 8;

    localparam logic [MUL_W-1:0] RECIP3  = 32'd43691;
    localparam int               SHIFT3  = 17;
    localparam logic [MUL_W-1:0] RECIP10 = 32'd52429;
    localparam int               SHIFT10 = 19;

    typedef enum logic [3:0] {
        CZ    = 4'd0,
        CP1   = 4'd1,
        CM1   = 4'd2,
        CP43  = 4'd3,
        CM23  = 4'd4,
        CP78  = 4'd5,
        CM78  = 4'd6,
        CP12  = 4'd7,
        CM12  = 4'd8,
        CP34  = 4'd9,
        CM34  = 4'd10,
        CP710 = 4'd11,
        CM710 = 4'd12
    } t_coef;

    typedef enum logic [2:0] {
        REG_FRAME_TYPE   = 3'd0,
        REG_MIN_THROTTLE = 3'd1,
        REG_MAX_THROTTLE = 3'd2,
        REG_MIN_CHECK    = 3'd3,
        REG_MIN_COMMAND  = 3'd4,
        REG_HEADROOM     = 3'd5,
        REG_IDLE_STOP    = 3'd6,
        REG_FAST_THR     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_type;
        logic [CMD_W-1:0]   min_throttle;
        logic [CMD_W-1:0]   max_throttle;
        logic [CMD_W-1:0]   min_check;
        logic [CMD_W-1:0]   min_command;
        logic [CNT_W-1:0]   headroom_motors;
        logic               idle_stop;
        logic               fast_throttle_change;
    } t_cfg;

    typedef struct packed {
        logic [SH_W-1:0]  sh;
        logic [CNT_W-1:0] lim;
        logic [CNT_W-1:0] cnt;
        logic             low;
        logic             armed;
    } t_side;

    localparam logic [CNT_W-1:0] FRAME_COUNT [NUM_FRAMES] = '{
        4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd8, 4'd8, 4'd4
    };

    localparam t_coef MIX_TAB [NUM_FRAMES][TABLE_MOTORS][3] = '{
        '{ '{CZ, CP1, CM1}, '{CM1, CZ, CP1}, '{CP1, CZ, CP1}, '{CZ, CM1, CM1},
           '{CZ, CZ, CZ}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ} },
        '{ '{CM1, CP1, CM1}, '{CM1, CM1, CP1}, '{CP1, CP1, CP1}, '{CP1, CM1, CM1},
           '{CZ, CZ, CZ}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ} },
        '{ '{CZ, CP1, CM1}, '{CM1, CM1, CZ}, '{CZ, CP1, CP1}, '{CP1, CM1, CZ},
           '{CZ, CZ, CZ}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ} },
        '{ '{CZ, CP43, CP1}, '{CM1, CM23, CM1}, '{CP1, CM23, CM1}, '{CZ, CP43, CM1},
           '{CM1, CM23, CP1}, '{CP1, CM23, CP1}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ} },
        '{ '{CM78, CP12, CP1}, '{CM78, CM12, CM1}, '{CP78, CP12, CP1}, '{CP78, CM12, CM1},
           '{CZ, CM1, CP1}, '{CZ, CP1, CM1}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ} },
        '{ '{CM12, CP78, CP1}, '{CM12, CM78, CP1}, '{CP12, CP78, CM1}, '{CP12, CM78, CM1},
           '{CM1, CZ, CM1}, '{CP1, CZ, CP1}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ} },
        '{ '{CM12, CP1, CP1}, '{CM34, CM1, CP1}, '{CP12, CP1, CM1}, '{CP34, CM1, CM1},
           '{CM78, CZ, CM1}, '{CP78, CZ, CP1}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ} },
        '{ '{CM1, CP1, CM1}, '{CM1, CM1, CP1}, '{CP1, CP1, CP1}, '{CP1, CM1, CM1},
           '{CZ, CZ, CZ}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ} },
        '{ '{CM1, CP1, CM1}, '{CM1, CM1, CP1}, '{CP1, CP1, CP1}, '{CP1, CM1, CM1},
           '{CM1, CP1, CP1}, '{CM1, CM1, CM1}, '{CP1, CP1, CM1}, '{CP1, CM1, CP1} },
        '{ '{CP710, CM710, CP1}, '{CM710, CM710, CP1}, '{CM710, CP710, CP1},
           '{CP710, CP710, CP1},
           '{CZ, CM1, CM1}, '{CM1, CZ, CM1}, '{CZ, CP1, CM1}, '{CP1, CZ, CM1} },
        '{ '{CP1, CM12, CP1}, '{CM12, CM1, CP1}, '{CM1, CP12, CP1}, '{CP12, CP1, CP1},
           '{CP12, CM1, CM1}, '{CM1, CM12, CM1}, '{CM12, CP1, CM1}, '{CP1, CP12, CM1} },
        '{ '{CZ, CP1, CP1}, '{CM1, CM1, CZ}, '{CZ, CP1, CM1}, '{CP1, CM1, CZ},
           '{CZ, CZ, CZ}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ}, '{CZ, CZ, CZ} }
    };

    function automatic logic [CNT_W-1:0] frame_count(input logic [FRAME_W-1:0] f);
        logic [CNT_W-1:0] n;
        n = '0;
        if (f < FRAME_W'(NUM_FRAMES)) begin
            n = FRAME_COUNT[f];
        end
        return n;
    endfunction

    function automatic t_coef mix_coef(input logic [FRAME_W-1:0] f,
                                       input logic [TAB_IDX_W-1:0] m,
                                       input logic [1:0] axis);
        t_coef c;
        c = CZ;
        if (f < FRAME_W'(NUM_FRAMES) && axis != 2'd3) begin
            c = MIX_TAB[f][m][axis];
        end
        return c;
    endfunction

    // x * n / d, truncated toward zero
    function automatic logic signed [TERM_W-1:0] apply_coef(
        input logic signed [CORR_W-1:0] x, input t_coef c);
        logic [CORR_W-1:0] a;
        logic [PRD_W-1:0]  p;
        logic [MUL_W-1:0]  prod;
        logic [TERM_W-1:0] q;
        logic              neg;
        a    = x[CORR_W-1] ? CORR_W'(-x) : CORR_W'(x);
        p    = '0;
        prod = '0;
        q    = '0;
        neg  = (c == CM1) || (c == CM23) || (c == CM78) || (c == CM12) ||
               (c == CM34) || (c == CM710);
        unique case (c)
            CZ: q = '0;
            CP1, CM1: q = TERM_W'(a);
            CP43: begin
                p    = PRD_W'(a) << 2;
                prod = MUL_W'(p) * RECIP3;
                q    = TERM_W'(prod >> SHIFT3);
            end
            CM23: begin
                p    = PRD_W'(a) << 1;
                prod = MUL_W'(p) * RECIP3;
                q    = TERM_W'(prod >> SHIFT3);
            end
            CP78, CM78: begin
                p = PRD_W'(a) * PRD_W'(7);
                q = TERM_W'(p >> 3);
            end
            CP12, CM12: q = TERM_W'(a >> 1);
            CP34, CM34: begin
                p = PRD_W'(a) * PRD_W'(3);
                q = TERM_W'(p >> 2);
            end
            CP710, CM710: begin
                p    = PRD_W'(a) * PRD_W'(7);
                prod = MUL_W'(p) * RECIP10;
                q    = TERM_W'(prod >> SHIFT10);
            end
            default: q = '0;
        endcase
        return (x[CORR_W-1] ^ neg) ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== hw/rtl/mmx_fifo.sv =====
// Two-entry queue between the mixing front end and the result sequencer.
module mmx_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    import mmx_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [PTR_W:0]   r_cnt, n_cnt;
    logic             push_ok, pop_ok;

    assign o_ready = (r_cnt != (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr  = push_ok ? r_wr + 1'b1 : r_wr;
        n_rd  = pop_ok ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (PTR_W+1)'(push_ok) - (PTR_W+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/mmx_front.sv =====
// Front end: accepts items, mixes one motor per cycle unless held by a full queue, and finds the headroom shift.
module mmx_front #(
    parameter int MAX_MOTORS = mmx_pkg::DEF_MAX_MOTORS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mmx_pkg::t_cfg                   i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mmx_pkg::CMD_W-1:0]       i_throttle_command,
    input  logic signed [mmx_pkg::CORR_W-1:0] i_roll_correction,
    input  logic signed [mmx_pkg::CORR_W-1:0] i_pitch_correction,
    input  logic signed [mmx_pkg::CORR_W-1:0] i_yaw_correction,
    input  logic [mmx_pkg::CMD_W-1:0]       i_raw_throttle,
    input  logic                            i_armed,
    input  logic                            i_altitude_hold,
    output logic                            o_push,
    output logic [MAX_MOTORS-1:0][mmx_pkg::MIX_W-1:0] o_mix,
    output mmx_pkg::t_side                  o_side,
    input  logic                            i_queue_ready
);
    import mmx_pkg::*;

    localparam int IDX_W = $clog2(MAX_MOTORS);

    logic [CMD_W-1:0]         r_thr;
    logic signed [CORR_W-1:0] r_roll, r_pitch, r_yaw;
    logic [CMD_W-1:0]         r_raw;
    logic                     r_armed, r_alt;
    logic                     r_busy;
    logic [IDX_W-1:0]         r_mot;

    logic                     r_b_valid;
    logic [IDX_W-1:0]         r_b_idx;
    logic                     r_b_last;
    logic [CMD_W-1:0]         r_b_thr;
    logic signed [TERM_W-1:0] r_b_t0, r_b_t1, r_b_t2;
    logic [CNT_W-1:0]         r_b_lim, r_b_cnt;
    logic                     r_b_low, r_b_armed;

    logic signed [MIX_W-1:0]  r_m [MAX_MOTORS];
    logic signed [MIX_W-1:0]  r_mx;

    logic [CNT_W-1:0]         cnt, lim, tab_cnt;
    logic                     frame_ok, en, a_fire, a_last, acc, low;
    logic [TAB_IDX_W-1:0]     tab_mot;
    logic signed [MIX_W-1:0]  b_mix, mx_new, hi;

    always_comb begin
        tab_cnt  = frame_count(i_cfg.frame_type);
        frame_ok = (tab_cnt != '0);
        cnt      = (tab_cnt > CNT_W'(MAX_MOTORS)) ? CNT_W'(MAX_MOTORS) : tab_cnt;
        lim      = (i_cfg.headroom_motors != '0) ? i_cfg.headroom_motors : cnt;
        if (lim > cnt) begin
            lim = cnt;
        end
        low      = (r_raw < i_cfg.min_check) && (i_cfg.fast_throttle_change || !r_alt);
        tab_mot  = TAB_IDX_W'(r_mot);
        a_last   = (CNT_W'(r_mot) == cnt - 1'b1);
    end

    assign en      = !(r_b_valid && r_b_last && !i_queue_ready);
    assign a_fire  = en && r_busy;
    assign o_ready = !r_busy || (a_fire && a_last);
    assign acc     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (acc) begin
            r_busy <= frame_ok;
        end else if (a_fire && a_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_thr   <= i_throttle_command;
            r_roll  <= i_roll_correction;
            r_pitch <= i_pitch_correction;
            r_yaw   <= i_yaw_correction;
            r_raw   <= i_raw_throttle;
            r_armed <= i_armed;
            r_alt   <= i_altitude_hold;
            r_mot   <= '0;
        end else if (a_fire) begin
            r_mot   <= r_mot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_idx   <= r_mot;
            r_b_last  <= a_last;
            r_b_thr   <= r_thr;
            r_b_t0    <= apply_coef(r_roll,  mix_coef(i_cfg.frame_type, tab_mot, 2'd0));
            r_b_t1    <= apply_coef(r_pitch, mix_coef(i_cfg.frame_type, tab_mot, 2'd1));
            r_b_t2    <= apply_coef(r_yaw,   mix_coef(i_cfg.frame_type, tab_mot, 2'd2));
            r_b_lim   <= lim;
            r_b_cnt   <= cnt;
            r_b_low   <= low;
            r_b_armed <= r_armed;
        end
    end

    always_comb begin
        b_mix = MIX_W'($signed({1'b0, r_b_thr})) + MIX_W'(r_b_t0) + MIX_W'(r_b_t1)
              + MIX_W'(r_b_t2);
        hi    = MIX_W'($signed({1'b0, i_cfg.max_throttle}));
        if (r_b_idx == '0) begin
            mx_new = b_mix;
        end else if ((CNT_W'(r_b_idx) < r_b_lim) && (b_mix > r_mx)) begin
            mx_new = b_mix;
        end else begin
            mx_new = r_mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && en) begin
            r_m[r_b_idx] <= b_mix;
            r_mx         <= mx_new;
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_MOTORS; k++) begin
            o_mix[k] = (IDX_W'(k) == r_b_idx) ? b_mix : r_m[k];
        end
        o_side.sh    = (mx_new > hi) ? SH_W'(mx_new - hi) : '0;
        o_side.lim   = r_b_lim;
        o_side.cnt   = r_b_cnt;
        o_side.low   = r_b_low;
        o_side.armed = r_b_armed;
        o_push       = r_b_valid && r_b_last;
    end

endmodule

// ===== hw/rtl/mmx_back.sv =====
// Back end: shifts, clamps and gates each motor command and emits one result per motor.
module mmx_back #(
    parameter int MAX_MOTORS = mmx_pkg::DEF_MAX_MOTORS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  mmx_pkg::t_cfg                             i_cfg,
    input  logic                                      i_q_valid,
    input  logic [MAX_MOTORS-1:0][mmx_pkg::MIX_W-1:0] i_q_mix,
    input  mmx_pkg::t_side                            i_q_side,
    output logic                                      o_q_pop,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [mmx_pkg::OUT_IDX_W-1:0]             o_motor_index,
    output logic [mmx_pkg::CMD_W-1:0]                 o_motor_value,
    output logic                                      o_last_motor
);
    import mmx_pkg::*;

    localparam int IDX_W = $clog2(MAX_MOTORS);

    logic [MAX_MOTORS-1:0][MIX_W-1:0] r_cur_mix;
    t_side                   r_cur_side;
    logic                    r_have;
    logic [IDX_W-1:0]        r_i;
    logic                    r_out_valid;
    logic [OUT_IDX_W-1:0]    r_out_idx;
    logic [CMD_W-1:0]        r_out_val;
    logic                    r_out_last;

    logic                    adv, emit, last_i, pop;
    logic signed [MIX_W-1:0] m_sel;
    logic [SH_W-1:0]         sub;
    logic signed [VAL_W-1:0] v, lo, hi;
    logic [CMD_W-1:0]        clamped, n_val;

    assign adv     = !r_out_valid || i_ready;
    assign emit    = adv && r_have;
    assign last_i  = (CNT_W'(r_i) == r_cur_side.cnt - 1'b1);
    assign pop     = adv && (!r_have || last_i) && i_q_valid;
    assign o_q_pop = pop;

    always_comb begin
        m_sel = $signed(r_cur_mix[r_i]);
        sub   = (CNT_W'(r_i) < r_cur_side.lim) ? r_cur_side.sh : '0;
        v     = VAL_W'(m_sel) - VAL_W'($signed({1'b0, sub}));
        lo    = VAL_W'($signed({1'b0, i_cfg.min_throttle}));
        hi    = VAL_W'($signed({1'b0, i_cfg.max_throttle}));
        priority if (v < lo) begin
            clamped = i_cfg.min_throttle;
        end else if (v > hi) begin
            clamped = i_cfg.max_throttle;
        end else begin
            clamped = CMD_W'(v);
        end
        n_val = clamped;
        if (i_cfg.headroom_motors != '0) begin
            if (r_cur_side.low && !r_cur_side.armed) begin
                n_val = i_cfg.min_command;
            end
        end else begin
            if (r_cur_side.low) begin
                n_val = i_cfg.idle_stop ? i_cfg.min_command : i_cfg.min_throttle;
            end
            if (!r_cur_side.armed) begin
                n_val = i_cfg.min_command;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_have;
            if (pop) begin
                r_have <= 1'b1;
            end else if (emit && last_i) begin
                r_have <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur_mix  <= i_q_mix;
            r_cur_side <= i_q_side;
            r_i        <= '0;
        end else if (emit) begin
            r_i        <= r_i + 1'b1;
        end
        if (emit) begin
            r_out_idx  <= OUT_IDX_W'(r_i);
            r_out_val  <= n_val;
            r_out_last <= last_i;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_motor_index = r_out_idx;
    assign o_motor_value = r_out_val;
    assign o_last_motor  = r_out_last;

endmodule

// ===== hw/rtl/multirotor_motor_mixer.sv =====
// Multirotor motor mixer top level: register port, front end, queue and back end.
//
// Each accepted item yields one result per motor of the configured frame (4, 6 or 8,
// capped at MAX_MOTORS), in motor order, with o_last_motor on the final one; frame types
// 12 to 15 yield none. The result sequencer emits one motor command per cycle while
// i_ready allows, with no gap between queued items. The front end mixes one motor per
// cycle unless held by a full queue and pushes the item from the register stage behind
// its last motor; the back end pops it into its current-item registers and then
// registers each command in its output register. A two-entry queue lets the front end
// run ahead of a stalled output. Registers sit at byte address 4*i on the APB port,
// are read back as written and must only change while the block is idle.
module multirotor_motor_mixer #(
    parameter int MAX_MOTORS = mmx_pkg::DEF_MAX_MOTORS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mmx_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mmx_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mmx_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [mmx_pkg::CMD_W-1:0]           i_throttle_command,
    input  logic signed [mmx_pkg::CORR_W-1:0]   i_roll_correction,
    input  logic signed [mmx_pkg::CORR_W-1:0]   i_pitch_correction,
    input  logic signed [mmx_pkg::CORR_W-1:0]   i_yaw_correction,
    input  logic [mmx_pkg::CMD_W-1:0]           i_raw_throttle,
    input  logic                                i_armed,
    input  logic                                i_altitude_hold,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mmx_pkg::OUT_IDX_W-1:0]       o_motor_index,
    output logic [mmx_pkg::CMD_W-1:0]           o_motor_value,
    output logic                                o_last_motor
);
    import mmx_pkg::*;

    localparam int ENTRY_W = $bits(t_side) + MAX_MOTORS * MIX_W;

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    logic                             f_push, q_ready, q_valid, q_pop;
    logic [MAX_MOTORS-1:0][MIX_W-1:0] f_mix, q_mix;
    t_side                            f_side, q_side;
    logic [ENTRY_W-1:0]               q_data;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_type           <= FRAME_W'(1);
            r_cfg.min_throttle         <= CMD_W'(1150);
            r_cfg.max_throttle         <= CMD_W'(1850);
            r_cfg.min_check            <= CMD_W'(1100);
            r_cfg.min_command          <= CMD_W'(1000);
            r_cfg.headroom_motors      <= '0;
            r_cfg.idle_stop            <= 1'b0;
            r_cfg.fast_throttle_change <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_FRAME_TYPE:   r_cfg.frame_type           <= pwdata[FRAME_W-1:0];
                REG_MIN_THROTTLE: r_cfg.min_throttle         <= pwdata[CMD_W-1:0];
                REG_MAX_THROTTLE: r_cfg.max_throttle         <= pwdata[CMD_W-1:0];
                REG_MIN_CHECK:    r_cfg.min_check            <= pwdata[CMD_W-1:0];
                REG_MIN_COMMAND:  r_cfg.min_command          <= pwdata[CMD_W-1:0];
                REG_HEADROOM:     r_cfg.headroom_motors      <= pwdata[CNT_W-1:0];
                REG_IDLE_STOP:    r_cfg.idle_stop            <= pwdata[0];
                REG_FAST_THR:     r_cfg.fast_throttle_change <= pwdata[0];
                default:          r_cfg.idle_stop            <= r_cfg.idle_stop;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FRAME_TYPE:   prdata = APB_DATA_W'(r_cfg.frame_type);
            REG_MIN_THROTTLE: prdata = APB_DATA_W'(r_cfg.min_throttle);
            REG_MAX_THROTTLE: prdata = APB_DATA_W'(r_cfg.max_throttle);
            REG_MIN_CHECK:    prdata = APB_DATA_W'(r_cfg.min_check);
            REG_MIN_COMMAND:  prdata = APB_DATA_W'(r_cfg.min_command);
            REG_HEADROOM:     prdata = APB_DATA_W'(r_cfg.headroom_motors);
            REG_IDLE_STOP:    prdata = APB_DATA_W'(r_cfg.idle_stop);
            REG_FAST_THR:     prdata = APB_DATA_W'(r_cfg.fast_throttle_change);
            default:          prdata = '0;
        endcase
    end

    mmx_front #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_throttle_command (i_throttle_command),
        .i_roll_correction  (i_roll_correction),
        .i_pitch_correction (i_pitch_correction),
        .i_yaw_correction   (i_yaw_correction),
        .i_raw_throttle     (i_raw_throttle),
        .i_armed            (i_armed),
        .i_altitude_hold    (i_altitude_hold),
        .o_push             (f_push),
        .o_mix              (f_mix),
        .o_side             (f_side),
        .i_queue_ready      (q_ready)
    );

    mmx_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_side, f_mix}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    assign q_mix  = q_data[MAX_MOTORS*MIX_W-1:0];
    assign q_side = t_side'(q_data[ENTRY_W-1:MAX_MOTORS*MIX_W]);

    mmx_back #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_mix       (q_mix),
        .i_q_side      (q_side),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_motor_index (o_motor_index),
        .o_motor_value (o_motor_value),
        .o_last_motor  (o_last_motor)
    );

endmodule
